>>> hw/rtl/bic_pkg.sv
// Shared constants, codes, types and arithmetic helpers of the bedding
// intersection classifier. No dependencies; every other file imports it.
package bic_pkg;

    // Field widths of the cell and result words.
    localparam int SLOPE_W  = 14;
    localparam int ASPECT_W = 16;
    localparam int DIP_W    = 14;
    localparam int DIPDIR_W = 16;
    localparam int CLASS_W  = 4;
    localparam int INDEX_W  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_GLOBAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_DIP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_DIPDIR = 2'd2;

    localparam logic [DIP_W-1:0]    RST_GLOBAL_DIP    = 14'd5760;
    localparam logic [DIPDIR_W-1:0] RST_GLOBAL_DIPDIR = 16'd11520;

    // Conformity classes.
    localparam logic [CLASS_W-1:0] CLS_UNDERDIP     = 4'd0;
    localparam logic [CLASS_W-1:0] CLS_DIP          = 4'd1;
    localparam logic [CLASS_W-1:0] CLS_OVERDIP      = 4'd2;
    localparam logic [CLASS_W-1:0] CLS_STEEPENED    = 4'd3;
    localparam logic [CLASS_W-1:0] CLS_NORMAL       = 4'd4;
    localparam logic [CLASS_W-1:0] CLS_SUBDUED      = 4'd5;
    localparam logic [CLASS_W-1:0] CLS_ORTHOCLINAL  = 4'd6;
    localparam logic [CLASS_W-1:0] CLS_NODATA       = 4'd7;
    localparam logic [CLASS_W-1:0] CLS_UNCLASSIFIED = 4'd8;

    // Angles are 32-bit turn fractions. Radians scale by TURN_PER_RAD, then
    // shift by the fraction bits. Degrees (1/128 steps) are v * 2^22 / 45,
    // done as a multiplication by an exact reciprocal.
    localparam logic [29:0] TURN_PER_RAD = 30'd683565275;
    localparam logic [38:0] DEG_RCP      = 39'(((64'd1 << 44) + 64'd44) / 64'd45);
    localparam int          DEG_SHIFT    = 22;

    // Scales of the dip minus slope test.
    localparam logic [13:0] DIP_SCALE   = 14'd10000;
    localparam logic [26:0] SLOPE_SCALE = 27'd73338624;  // 128 * 572958
    localparam longint      BOUND_BASE  = 64'd6400000;   // 5 deg * 128 * 10^4

    // Chord thresholds in Q30 of e^2, brought into integer form.
    localparam logic [34:0] E2_LO  = 35'(((64'd58583716) << 30) / 64'd100000000);
    localparam logic [34:0] E2_HI  = 35'(((64'd341436484) << 30) / 64'd100000000);
    localparam logic [34:0] E2_TOP = 35'(64'd4 << 30);

    // Sine and cosine unit.
    localparam int          SC_LAT  = 15;
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'(64'd1 << 30);

    // Reciprocals for the Taylor divisors: q = (t * RCP) >> SHF is exact
    // for t below 2^30.
    localparam logic [31:0] SIN_RCP [6] = '{
        32'(((64'd1 << 33) + 64'd5)   / 64'd6),
        32'(((64'd1 << 35) + 64'd19)  / 64'd20),
        32'(((64'd1 << 36) + 64'd41)  / 64'd42),
        32'(((64'd1 << 37) + 64'd71)  / 64'd72),
        32'(((64'd1 << 37) + 64'd109) / 64'd110),
        32'(((64'd1 << 38) + 64'd155) / 64'd156)
    };
    localparam int SIN_SHF [6] = '{33, 35, 36, 37, 37, 38};
    localparam logic [31:0] COS_RCP [6] = '{
        32'(((64'd1 << 31) + 64'd1)   / 64'd2),
        32'(((64'd1 << 34) + 64'd11)  / 64'd12),
        32'(((64'd1 << 35) + 64'd29)  / 64'd30),
        32'(((64'd1 << 36) + 64'd55)  / 64'd56),
        32'(((64'd1 << 37) + 64'd89)  / 64'd90),
        32'(((64'd1 << 38) + 64'd131) / 64'd132)
    };
    localparam int COS_SHF [6] = '{31, 34, 35, 36, 37, 38};

    typedef struct packed {
        logic [CLASS_W-1:0]        class_code;
        logic signed [INDEX_W-1:0] conformity_index;
        logic                      index_valid;
    } t_result;

    // Q30 product, truncated toward zero.
    function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic [31:0] ua;
        logic [31:0] ub;
        logic [63:0] m;
        logic [31:0] q;
        ua = a[31] ? 32'(-a) : 32'(a);
        ub = b[31] ? 32'(-b) : 32'(b);
        m  = ua * ub;
        q  = m[61:30];
        return (a[31] ^ b[31]) ? signed'(32'd0 - q) : signed'(q);
    endfunction

endpackage

>>> hw/rtl/bic_cell_if.sv
// Input channel of the classifier: one raster cell word with valid/ready.
// Depends on bic_pkg for the field widths.
interface bic_cell_if import bic_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SLOPE_W-1:0]  slope;
    logic [ASPECT_W-1:0] aspect;
    logic [DIP_W-1:0]    cell_dip;
    logic [DIPDIR_W-1:0] cell_dip_direction;
    logic                slope_missing;
    logic                structure_missing;

    modport source (output valid, slope, aspect, cell_dip, cell_dip_direction,
                    slope_missing, structure_missing, input ready);
    modport sink   (input valid, slope, aspect, cell_dip, cell_dip_direction,
                    slope_missing, structure_missing, output ready);
endinterface

>>> hw/rtl/bic_result_if.sv
// Output channel of the classifier: one class and index word with valid/ready.
// Depends on bic_pkg for the field widths.
interface bic_result_if import bic_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CLASS_W-1:0]        class_code;
    logic signed [INDEX_W-1:0] conformity_index;
    logic                      index_valid;

    modport source (output valid, class_code, conformity_index, index_valid,
                    input ready);
    modport sink   (input valid, class_code, conformity_index, index_valid,
                    output ready);
endinterface

>>> hw/rtl/bic_sincos.sv
// Pipelined Q30 sine and cosine of a 32-bit turn fraction: octant reduction
// and a seven-term Taylor series, one multiply or one divide per stage.
// Depends on bic_pkg (reciprocal tables, PI_Q30, ONE_Q30).
module bic_sincos import bic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [31:0]        i_phase,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    typedef struct packed {
        logic [30:0]        st;
        logic [30:0]        ct;
        logic signed [32:0] sa;
        logic signed [32:0] ca;
        logic [29:0]        x2;
        logic [1:0]         quad;
        logic               swap;
    } t_sc_stage;

    logic [29:0] r_x;
    logic [1:0]  r_quad;
    logic        r_swap;
    t_sc_stage   r_ch [0:12];
    t_sc_stage   n_ch [0:12];

    logic [29:0] n_rr;
    logic [61:0] n_xprod;
    logic [59:0] n_x2prod;

    logic [60:0] n_sp [0:5];
    logic [60:0] n_cp [0:5];
    logic [62:0] n_sq [0:5];
    logic [62:0] n_cq [0:5];
    logic [30:0] n_st [0:5];
    logic [30:0] n_ct [0:5];

    assign n_rr     = i_phase[29] ? 30'(31'h4000_0000 - {1'b0, i_phase[29:0]})
                                  : i_phase[29:0];
    assign n_xprod  = n_rr * PI_Q30;
    assign n_x2prod = r_x * r_x;

    // Each term takes two stages: the product with x^2, then the divide.
    always_comb begin
        n_ch[0].st   = {1'b0, r_x};
        n_ch[0].ct   = ONE_Q30;
        n_ch[0].sa   = 33'(r_x);
        n_ch[0].ca   = 33'(ONE_Q30);
        n_ch[0].x2   = n_x2prod[59:30];
        n_ch[0].quad = r_quad;
        n_ch[0].swap = r_swap;
        for (int k = 0; k < 6; k++) begin
            n_sp[k] = r_ch[2*k].st * r_ch[2*k].x2;
            n_cp[k] = r_ch[2*k].ct * r_ch[2*k].x2;
            n_sq[k] = r_ch[2*k+1].st * SIN_RCP[k];
            n_cq[k] = r_ch[2*k+1].ct * COS_RCP[k];
            n_st[k] = 31'(n_sq[k] >> SIN_SHF[k]);
            n_ct[k] = 31'(n_cq[k] >> COS_SHF[k]);

            n_ch[2*k+1]    = r_ch[2*k];
            n_ch[2*k+1].st = n_sp[k][60:30];
            n_ch[2*k+1].ct = n_cp[k][60:30];

            n_ch[2*k+2]    = r_ch[2*k+1];
            n_ch[2*k+2].st = n_st[k];
            n_ch[2*k+2].ct = n_ct[k];
            // Terms alternate in sign, starting with a subtraction.
            if ((k & 1) == 0) begin
                n_ch[2*k+2].sa = r_ch[2*k+1].sa - 33'(n_st[k]);
                n_ch[2*k+2].ca = r_ch[2*k+1].ca - 33'(n_ct[k]);
            end else begin
                n_ch[2*k+2].sa = r_ch[2*k+1].sa + 33'(n_st[k]);
                n_ch[2*k+2].ca = r_ch[2*k+1].ca + 33'(n_ct[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_xprod[60:31];
            r_quad <= i_phase[31:30];
            r_swap <= i_phase[29];
            for (int i = 0; i < 13; i++) begin
                r_ch[i] <= n_ch[i];
            end
        end
    end

    logic signed [31:0] n_s;
    logic signed [31:0] n_c;
    logic signed [31:0] n_sin;
    logic signed [31:0] n_cos;

    always_comb begin
        n_s = r_ch[12].swap ? 32'(r_ch[12].ca) : 32'(r_ch[12].sa);
        n_c = r_ch[12].swap ? 32'(r_ch[12].sa) : 32'(r_ch[12].ca);
        case (r_ch[12].quad)
            2'd0:    begin n_sin = n_s;  n_cos = n_c;  end
            2'd1:    begin n_sin = n_c;  n_cos = -n_s; end
            2'd2:    begin n_sin = -n_s; n_cos = -n_c; end
            default: begin n_sin = -n_c; n_cos = n_s;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sin <= n_sin;
            o_cos <= n_cos;
        end
    end

endmodule

>>> hw/rtl/bedding_intersection_classifier.sv
// Top level of the bedding intersection classifier: cell stream in, class and
// conformity index out. Depends on bic_pkg, bic_cell_if, bic_result_if, bic_sincos.
//
//  Port        Dir  Kind             Content
//  i_cell      in   valid/ready      slope, aspect, cell dip, dip direction, flags
//  o_result    out  valid/ready      class code, conformity index, index valid
//  i_cfg_*     in   write only       global mode, global dip, global dip direction
//
// One cell word enters per clock while i_cell.ready is high. From acceptance to the
// result word it passes three front stages, the 15-stage sine and cosine
// pipelines, three back stages and the output register.
// Reset is synchronous and active low; it empties the pipeline and loads the
// configuration registers with their defaults.
// A stall on o_result fills one skid word; only then does i_cell.ready drop
// and the whole pipeline hold, so no word is lost or repeated.
module bedding_intersection_classifier import bic_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int INDEX_FRAC_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bic_cell_if.sink              i_cell,
    bic_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Width of the scaled dip minus slope difference.
    localparam int DW = 28 + ANGLE_FRAC_BITS + 2;
    localparam logic signed [DW-1:0] BOUND = DW'(BOUND_BASE << ANGLE_FRAC_BITS);
    localparam int SH = 30 - INDEX_FRAC_BITS;
    localparam logic [33:0] RND = 34'(64'd1 << (SH - 1));
    localparam logic [33:0] IDX_ONE = 34'(64'd1 << INDEX_FRAC_BITS);

    typedef struct packed {
        logic nodata;
        logic above;   // dip - slope above +5 degrees
        logic below;   // dip - slope below -5 degrees
    } t_side;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic                r_use_global;
    logic [DIP_W-1:0]    r_gdip;
    logic [DIPDIR_W-1:0] r_gdipdir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_global <= 1'b1;
            r_gdip       <= RST_GLOBAL_DIP;
            r_gdipdir    <= RST_GLOBAL_DIPDIR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_USE_GLOBAL:    r_use_global <= i_cfg_data[0];
                CFG_GLOBAL_DIP:    r_gdip       <= i_cfg_data[DIP_W-1:0];
                CFG_GLOBAL_DIPDIR: r_gdipdir    <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline enable: everything advances unless the skid word is full.
    // ------------------------------------------------------------------
    logic    r_skid_v;
    logic    pipe_en;
    t_result r_skid;
    logic    r_out_v;
    t_result r_out;

    assign pipe_en      = !r_skid_v;
    assign i_cell.ready = pipe_en;

    // ------------------------------------------------------------------
    // Stage 1: capture the cell and pick the structure source.
    // ------------------------------------------------------------------
    logic                r1_v;
    logic [SLOPE_W-1:0]  r1_slope;
    logic [ASPECT_W-1:0] r1_aspect;
    logic [DIP_W-1:0]    r1_dip;
    logic [DIPDIR_W-1:0] r1_dipdir;
    logic                r1_nodata;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_slope  <= i_cell.slope;
            r1_aspect <= i_cell.aspect;
            r1_dip    <= r_use_global ? r_gdip : i_cell.cell_dip;
            r1_dipdir <= r_use_global ? r_gdipdir : i_cell.cell_dip_direction;
            // The per-cell structure flag only counts in per-cell mode.
            r1_nodata <= i_cell.slope_missing
                         | (!r_use_global & i_cell.structure_missing);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: convert all four angles to turn fractions and scale the
    // dip and slope for the difference test.
    // ------------------------------------------------------------------
    logic        r2_v;
    logic [31:0] r2_pa, r2_pb, r2_pc, r2_pd;
    logic [27:0] r2_dterm;
    logic [40:0] r2_sterm;
    logic        r2_nodata;

    logic [43:0] n_pa_prod;
    logic [45:0] n_pb_prod;
    logic [52:0] n_pc_prod;
    logic [54:0] n_pd_prod;

    assign n_pa_prod = r1_slope * TURN_PER_RAD;
    assign n_pb_prod = r1_aspect * TURN_PER_RAD;
    assign n_pc_prod = r1_dip * DEG_RCP;
    assign n_pd_prod = r1_dipdir * DEG_RCP;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r2_pa     <= 32'(n_pa_prod >> ANGLE_FRAC_BITS);
            r2_pb     <= 32'(n_pb_prod >> ANGLE_FRAC_BITS);
            r2_pc     <= 32'(n_pc_prod >> DEG_SHIFT);
            r2_pd     <= 32'(n_pd_prod >> DEG_SHIFT);
            r2_dterm  <= r1_dip * DIP_SCALE;
            r2_sterm  <= r1_slope * SLOPE_SCALE;
            r2_nodata <= r1_nodata;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: relative angle for the index, and the +-5 degree tests.
    // ------------------------------------------------------------------
    logic              r3_v;
    logic [31:0]       r3_pa, r3_pb, r3_pc, r3_pd, r3_pe;
    t_side             r3_side;
    logic signed [DW-1:0] n_diff;

    assign n_diff = signed'(DW'(r2_dterm) << ANGLE_FRAC_BITS) - signed'(DW'(r2_sterm));

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r3_pa          <= r2_pa;
            r3_pb          <= r2_pb;
            r3_pc          <= r2_pc;
            r3_pd          <= r2_pd;
            r3_pe          <= r2_pd - r2_pb;
            r3_side.nodata <= r2_nodata;
            r3_side.above  <= n_diff > BOUND;
            r3_side.below  <= n_diff < -BOUND;
        end
    end

    // ------------------------------------------------------------------
    // Sine and cosine of slope, aspect, dip, dip direction and the
    // dip direction relative to aspect, all in parallel.
    // ------------------------------------------------------------------
    logic signed [31:0] sa, ca, sb, cb, sc, cc, sd, cd, sx, cx;

    bic_sincos u_sc_slope (.i_clk, .i_en(pipe_en), .i_phase(r3_pa), .o_sin(sa), .o_cos(ca));
    bic_sincos u_sc_aspect(.i_clk, .i_en(pipe_en), .i_phase(r3_pb), .o_sin(sb), .o_cos(cb));
    bic_sincos u_sc_dip   (.i_clk, .i_en(pipe_en), .i_phase(r3_pc), .o_sin(sc), .o_cos(cc));
    bic_sincos u_sc_dipdir(.i_clk, .i_en(pipe_en), .i_phase(r3_pd), .o_sin(sd), .o_cos(cd));
    bic_sincos u_sc_rel   (.i_clk, .i_en(pipe_en), .i_phase(r3_pe), .o_sin(sx), .o_cos(cx));

    // Side information rides along the trig pipelines.
    logic  r_dl_v [0:SC_LAT-1];
    t_side r_dl   [0:SC_LAT-1];

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_dl[0] <= r3_side;
            for (int i = 1; i < SC_LAT; i++) begin
                r_dl[i] <= r_dl[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: chord components and the first index products.
    // ------------------------------------------------------------------
    logic               r4_v;
    logic signed [32:0] r4_dx, r4_dy;
    logic signed [31:0] r4_m1, r4_m2, r4_cx;
    t_side              r4_side;

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r4_dx   <= 33'(cd) - 33'(cb);
            r4_dy   <= 33'(sd) - 33'(sb);
            r4_m1   <= mul_q30(cc, ca);
            r4_m2   <= mul_q30(sc, sa);
            r4_cx   <= cx;
            r4_side <= r_dl[SC_LAT-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: squares of the chord components, last index product.
    // ------------------------------------------------------------------
    logic               r5_v;
    logic [63:0]        r5_sqx, r5_sqy;
    logic signed [31:0] r5_m1, r5_m3;
    t_side              r5_side;
    logic [31:0]        n_ax, n_ay;

    assign n_ax = r4_dx[32] ? 32'(-r4_dx) : 32'(r4_dx);
    assign n_ay = r4_dy[32] ? 32'(-r4_dy) : 32'(r4_dy);

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r5_sqx  <= n_ax * n_ax;
            r5_sqy  <= n_ay * n_ay;
            r5_m1   <= r4_m1;
            r5_m3   <= mul_q30(r4_m2, r4_cx);
            r5_side <= r4_side;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: classify on e^2 and round the index to the output format.
    // ------------------------------------------------------------------
    logic        r6_v;
    t_result     r6;
    logic [64:0] n_sqsum;
    logic [34:0] n_e2;
    logic        n_near, n_mid, n_far;
    logic [CLASS_W-1:0] n_cls;
    logic signed [33:0] n_f;
    logic [33:0] n_fmag, n_mag;
    logic signed [INDEX_W-1:0] n_idx;

    always_comb begin
        n_sqsum = 65'(r5_sqx) + 65'(r5_sqy);
        n_e2    = (n_sqsum[64:30] > E2_TOP) ? E2_TOP : n_sqsum[64:30];
        // e equal to 0.7654 cannot occur on the integer grid of e^2.
        n_near  = n_e2 <= E2_LO;
        n_mid   = n_e2 > E2_LO && n_e2 <= E2_HI;
        n_far   = n_e2 > E2_HI && n_e2 <= E2_TOP;

        if (n_near && r5_side.above)       n_cls = CLS_UNDERDIP;
        else if (n_near && !r5_side.below) n_cls = CLS_DIP;
        else if (n_near)                   n_cls = CLS_OVERDIP;
        else if (n_far && r5_side.below)   n_cls = CLS_STEEPENED;
        else if (n_far && !r5_side.above)  n_cls = CLS_NORMAL;
        else if (n_far)                    n_cls = CLS_SUBDUED;
        else if (n_mid)                    n_cls = CLS_ORTHOCLINAL;
        else                               n_cls = CLS_UNCLASSIFIED;

        // Round half away from zero, then saturate to +-1.0.
        n_f    = 34'(r5_m1) + 34'(r5_m3);
        n_fmag = n_f[33] ? 34'(-n_f) : 34'(n_f);
        n_mag  = (n_fmag + RND) >> SH;
        if (n_mag > IDX_ONE) begin
            n_mag = IDX_ONE;
        end
        n_idx  = n_f[33] ? signed'(INDEX_W'(34'd0 - n_mag)) : signed'(INDEX_W'(n_mag));
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            if (r5_side.nodata) begin
                r6.class_code       <= CLS_NODATA;
                r6.conformity_index <= '0;
                r6.index_valid      <= 1'b0;
            end else begin
                r6.class_code       <= n_cls;
                r6.conformity_index <= n_idx;
                r6.index_valid      <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid bits of all stages.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            for (int i = 0; i < SC_LAT; i++) begin
                r_dl_v[i] <= 1'b0;
            end
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (pipe_en) begin
            r1_v      <= i_cell.valid;
            r2_v      <= r1_v;
            r3_v      <= r2_v;
            r_dl_v[0] <= r3_v;
            for (int i = 1; i < SC_LAT; i++) begin
                r_dl_v[i] <= r_dl_v[i-1];
            end
            r4_v <= r_dl_v[SC_LAT-1];
            r5_v <= r4_v;
            r6_v <= r5_v;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid word behind it.
    // ------------------------------------------------------------------
    logic take;
    assign take = !r_out_v || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take) begin
            r_out_v  <= r_skid_v | (pipe_en & r6_v);
            r_skid_v <= 1'b0;
        end else if (pipe_en && r6_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= r_skid_v ? r_skid : r6;
        end else if (pipe_en && r6_v) begin
            r_skid <= r6;
        end
    end

    assign o_result.valid            = r_out_v;
    assign o_result.class_code       = r_out.class_code;
    assign o_result.conformity_index = r_out.conformity_index;
    assign o_result.index_valid      = r_out.index_valid;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held while the output register is empty");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !o_result.ready && r6_v))
        else $error("skid word filled without a stalled output");

    a_nodata_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.index_valid) |->
            (r_out.class_code == CLS_NODATA && r_out.conformity_index == '0))
        else $error("invalid index on a cell that is not no-data");

    a_valid_index_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.index_valid) |-> (r_out.class_code != CLS_NODATA))
        else $error("no-data class with a valid index");

endmodule
